// ===== rtl/jmcm_pkg.sv =====
// Shared constants, codes and tables of the joystick motion command mapper.
package jmcm_pkg;

  localparam int CfgW  = 16;
  localparam int CfgAw = 3;

  localparam logic [2:0] ACT_AXIS   = 3'd0;
  localparam logic [2:0] ACT_BUTTON = 3'd1;
  localparam logic [2:0] ACT_FACE   = 3'd2;
  localparam logic [2:0] ACT_BODY   = 3'd3;
  localparam logic [2:0] ACT_NONE   = 3'd4;

  localparam logic [CfgAw-1:0] REG_FULL_SCALE = 3'd0;
  localparam logic [CfgAw-1:0] REG_CEILING    = 3'd1;
  localparam logic [CfgAw-1:0] REG_STEP       = 3'd2;
  localparam logic [CfgAw-1:0] REG_HEAD_LIM   = 3'd3;
  localparam logic [CfgAw-1:0] REG_DIAG       = 3'd4;
  localparam logic [CfgAw-1:0] REG_SIDE       = 3'd5;
  localparam logic [CfgAw-1:0] REG_DEADBAND   = 3'd6;
  localparam logic [CfgAw-1:0] REG_FACE_PWM   = 3'd7;

  localparam logic [1:0] MODE_STOP = 2'd0;
  localparam logic [1:0] MODE_FWD  = 2'd1;
  localparam logic [1:0] MODE_BACK = 2'd3;

  localparam logic [7:0] AXIS_STICK_X = 8'd2;
  localparam logic [7:0] AXIS_STICK_Y = 8'd3;
  localparam logic [7:0] AXIS_DPAD_X  = 8'd6;
  localparam logic [7:0] AXIS_DPAD_Y  = 8'd7;
  localparam logic [7:0] BTN_INC      = 8'd0;
  localparam logic [7:0] BTN_DEC      = 8'd1;
  localparam logic [7:0] BTN_CLEAR    = 8'd3;

  localparam logic signed [15:0] STICK_FULL = 16'sd32767;
  localparam logic signed [15:0] STICK_MIN  = -16'sd32768;
  localparam int CordicSteps = 18;
  localparam logic signed [24:0] Z_MAX = 25'sd5898240;

  // CORDIC arctangent steps in units of 2^-16 degree
  function automatic logic [21:0] atan_step(input logic [4:0] i);
    logic [21:0] v;
    case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] sat_neg(input logic signed [15:0] v);
    return (v == STICK_MIN) ? STICK_FULL : -v;
  endfunction

endpackage

// ===== rtl/jmcm_if.sv =====
// Valid/ready channel interfaces for event items and command items.
interface jmcm_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic [7:0]         control_number;
  logic signed [15:0] control_value;
  logic [15:0]        face_x;
  modport source (output valid, action, control_number, control_value, face_x,
                  input ready);
  modport sink (input valid, action, control_number, control_value, face_x,
                output ready);
endinterface

interface jmcm_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         motor_mode;
  logic [11:0]        pwm_level;
  logic signed [15:0] heading_delta;
  modport source (output valid, motor_mode, pwm_level, heading_delta, input ready);
  modport sink (input valid, motor_mode, pwm_level, heading_delta, output ready);
endinterface

// ===== rtl/joystick_motion_command_mapper_core.sv =====
// Button, d-pad, face, vision and unused-control items go from accept straight to the
// result state, as do stick items that leave both axes at zero.
// Other stick items run a shared multiplier and, unless both magnitudes are equal or
// one magnitude is zero, a CORDIC sequencer.
// The core takes one item at a time; a stick item runs the 12-step square root/divide
// search on the shared multiplier and may then run the 18-step CORDIC loop.
// Reset (rst_n, synchronous, active low) clears the command, stick and d-pad state and
// loads the register defaults.
module joystick_motion_command_mapper_core
  import jmcm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  jmcm_in_if.sink          in_item,
  jmcm_out_if.source       out_item,
  input  logic             cfg_we,
  input  logic [CfgAw-1:0] cfg_addr,
  input  logic [CfgW-1:0]  cfg_wdata
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_T1   = 4'd1;
  localparam logic [3:0] S_T2   = 4'd2;
  localparam logic [3:0] S_T3   = 4'd3;
  localparam logic [3:0] S_T4   = 4'd4;
  localparam logic [3:0] S_SQA  = 4'd5;
  localparam logic [3:0] S_SQB  = 4'd6;
  localparam logic [3:0] S_COR  = 4'd7;
  localparam logic [3:0] S_END  = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [11:0] full_scale_r, ceiling_r, face_pwm_r;
  logic [7:0]  step_r;
  logic [14:0] head_lim_r;
  logic [13:0] diag_r, side_r;
  logic [15:0] deadband_r;

  logic [3:0]         state_r, state_nxt;
  logic signed [15:0] stick_x_r, stick_y_r, dpad_x_r, dpad_y_r;
  logic [1:0]         mode_r;
  logic [11:0]        pwm_r;
  logic signed [15:0] heading_r;

  logic [14:0]        ax_r, ay_r;
  logic               both_r;
  logic [29:0]        t1_r;
  logic [56:0]        mul_r, target_r;
  logic [11:0]        root_r;
  logic [3:0]         bit_r;
  logic signed [33:0] p_r, q_r;
  logic signed [24:0] z_r;
  logic [4:0]         i_r;

  logic               out_valid_r;
  logic [1:0]         out_mode_r;
  logic [11:0]        out_pwm_r;
  logic signed [15:0] out_head_r;

  logic in_acc;
  assign in_acc = in_item.valid && in_item.ready;
  assign in_item.ready = (state_r == S_IDLE);

  // new stick values as of this item
  logic signed [15:0] new_sx, new_sy, new_dx, new_dy, abs_x, abs_y;
  logic               stick_evt, dpad_evt;
  assign stick_evt = (in_item.action == ACT_AXIS) &&
                     (in_item.control_number == AXIS_STICK_X ||
                      in_item.control_number == AXIS_STICK_Y);
  assign dpad_evt  = (in_item.action == ACT_AXIS) &&
                     (in_item.control_number == AXIS_DPAD_X ||
                      in_item.control_number == AXIS_DPAD_Y);
  assign new_sx = (in_item.control_number == AXIS_STICK_X) ? in_item.control_value
                                                           : stick_x_r;
  assign new_sy = (in_item.control_number == AXIS_STICK_Y) ?
                  sat_neg(in_item.control_value) : stick_y_r;
  assign new_dx = (in_item.control_number == AXIS_DPAD_X) ? in_item.control_value
                                                          : dpad_x_r;
  assign new_dy = (in_item.control_number == AXIS_DPAD_Y) ?
                  sat_neg(in_item.control_value) : dpad_y_r;
  assign abs_x = new_sx[15] ? sat_neg(new_sx) : new_sx;
  assign abs_y = new_sy[15] ? sat_neg(new_sy) : new_sy;

  // shared multiplier
  logic [29:0] mul_a;
  logic [26:0] mul_b, cand_c;
  logic [11:0] cand;
  assign cand   = root_r | (12'd1 << bit_r);
  assign cand_c = ({15'd0, cand} << 15) - {15'd0, cand};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_T1: begin
        if (both_r) begin
          mul_a = {15'd0, ax_r};
          mul_b = {12'd0, ay_r};
        end else begin
          mul_a = {15'd0, (ax_r != 15'd0) ? ax_r : ay_r};
          mul_b = {15'd0, full_scale_r};
        end
      end
      S_T2: begin
        mul_a = {18'd0, full_scale_r};
        mul_b = {15'd0, full_scale_r};
      end
      S_T3: begin
        mul_a = t1_r;
        mul_b = mul_r[26:0];
      end
      S_SQA: begin
        mul_a = {3'd0, cand_c};
        mul_b = both_r ? cand_c : 27'd1;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // CORDIC step
  logic signed [33:0] dp, dq;
  logic signed [24:0] ang;
  assign dp  = q_r >>> i_r;
  assign dq  = p_r >>> i_r;
  assign ang = $signed({3'd0, atan_step(i_r)});

  // angle finish, fold and clamp
  logic [22:0]        z_cl;
  logic [29:0]        z_100;
  logic [13:0]        h_base;
  logic signed [15:0] h_s, folded, lim_s;
  logic               front;
  assign z_cl  = (z_r < 0) ? 23'd0 : (z_r > Z_MAX) ? Z_MAX[22:0] : z_r[22:0];
  assign z_100 = ({7'd0, z_cl} << 6) + ({7'd0, z_cl} << 5) + ({7'd0, z_cl} << 2);
  always_comb begin
    if (ax_r == 15'd0)      h_base = 14'd0;
    else if (ay_r == 15'd0) h_base = 14'd9000;
    else if (ax_r == ay_r)  h_base = 14'd4500;
    else                    h_base = z_100[29:16];
  end
  assign h_s    = $signed({2'b00, h_base});
  assign front  = !stick_y_r[15];
  assign folded = (front ^ stick_x_r[15]) ? h_s : -h_s;
  assign lim_s  = $signed({1'b0, head_lim_r});

  // face tracking
  logic signed [16:0] fd;
  logic [15:0]        fm;
  logic [29:0]        f9k;
  logic signed [15:0] ft;
  assign fd  = $signed({1'b0, in_item.face_x}) - 17'sd32768;
  assign fm  = fd[16] ? 16'((-fd)) : fd[15:0];
  assign f9k = {14'd0, fm} * 30'd9000;
  assign ft  = $signed({3'd0, f9k[28:16]});

  logic [12:0] pwm_sum;
  assign pwm_sum = {1'b0, pwm_r} + {5'd0, step_r};

  logic out_load;
  assign out_load = (state_r == S_FIN) && (!out_valid_r || out_item.ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (stick_evt && !(new_sx == 16'sd0 && new_sy == 16'sd0)) state_nxt = S_T1;
          else state_nxt = S_FIN;
        end
      end
      S_T1:  state_nxt = S_T2;
      S_T2:  state_nxt = both_r ? S_T3 : S_SQA;
      S_T3:  state_nxt = S_T4;
      S_T4:  state_nxt = S_SQA;
      S_SQA: state_nxt = S_SQB;
      S_SQB: begin
        if (bit_r != 4'd0) state_nxt = S_SQA;
        else if (ax_r == 15'd0 || ay_r == 15'd0 || ax_r == ay_r) state_nxt = S_END;
        else state_nxt = S_COR;
      end
      S_COR: state_nxt = (i_r == 5'(CordicSteps - 1)) ? S_END : S_COR;
      S_END: state_nxt = S_FIN;
      S_FIN: state_nxt = out_load ? S_IDLE : S_FIN;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_scale_r <= 12'd2499;
      ceiling_r    <= 12'd2449;
      step_r       <= 8'd10;
      head_lim_r   <= 15'd6000;
      diag_r       <= 14'd1000;
      side_r       <= 14'd4500;
      deadband_r   <= 16'd6554;
      face_pwm_r   <= 12'd10;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_FULL_SCALE: full_scale_r <= cfg_wdata[11:0];
        REG_CEILING:    ceiling_r    <= cfg_wdata[11:0];
        REG_STEP:       step_r       <= cfg_wdata[7:0];
        REG_HEAD_LIM:   head_lim_r   <= cfg_wdata[14:0];
        REG_DIAG:       diag_r       <= cfg_wdata[13:0];
        REG_SIDE:       side_r       <= cfg_wdata[13:0];
        REG_DEADBAND:   deadband_r   <= cfg_wdata;
        REG_FACE_PWM:   face_pwm_r   <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    mul_r <= 57'(mul_a * mul_b);
    case (state_r)
      S_IDLE: begin
        ax_r   <= abs_x[14:0];
        ay_r   <= abs_y[14:0];
        both_r <= (abs_x != 16'sd0) && (abs_y != 16'sd0);
        root_r <= '0;
        bit_r  <= 4'd11;
      end
      S_T2: begin
        t1_r     <= mul_r[29:0];
        target_r <= mul_r;
      end
      S_T4: target_r <= mul_r;
      S_SQB: begin
        if (mul_r <= target_r) root_r <= cand;
        bit_r <= bit_r - 4'd1;
        p_r   <= $signed({5'd0, ay_r, 14'd0});
        q_r   <= $signed({5'd0, ax_r, 14'd0});
        z_r   <= '0;
        i_r   <= '0;
      end
      S_COR: begin
        if (!q_r[33]) begin
          p_r <= p_r + dp;
          q_r <= q_r - dq;
          z_r <= z_r + ang;
        end else begin
          p_r <= p_r - dp;
          q_r <= q_r + dq;
          z_r <= z_r - ang;
        end
        i_r <= i_r + 5'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      stick_x_r <= '0;
      stick_y_r <= '0;
      dpad_x_r  <= '0;
      dpad_y_r  <= '0;
      mode_r    <= MODE_STOP;
      pwm_r     <= '0;
      heading_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_item.ready) out_valid_r <= 1'b0;
      if (in_acc) begin
        case (in_item.action)
          ACT_AXIS: begin
            if (stick_evt) begin
              stick_x_r <= new_sx;
              stick_y_r <= new_sy;
              if (new_sx == 16'sd0 && new_sy == 16'sd0) begin
                mode_r <= MODE_STOP;
                pwm_r <= '0;
                heading_r <= '0;
              end
            end else if (dpad_evt) begin
              dpad_x_r <= new_dx;
              dpad_y_r <= new_dy;
              if (new_dx == 16'sd0 && new_dy == 16'sd0) heading_r <= '0;
              else if (new_dx == 16'sd0 && new_dy == STICK_FULL) begin
                heading_r <= '0; mode_r <= MODE_FWD;
              end else if (new_dx == 16'sd0 && new_dy == -STICK_FULL) begin
                heading_r <= '0; mode_r <= MODE_BACK;
              end else if (new_dx == STICK_FULL && new_dy == STICK_FULL) begin
                heading_r <= $signed({2'b00, diag_r}); mode_r <= MODE_FWD;
              end else if (new_dx == -STICK_FULL && new_dy == STICK_FULL) begin
                heading_r <= -$signed({2'b00, diag_r}); mode_r <= MODE_FWD;
              end else if (new_dx == STICK_FULL && new_dy == 16'sd0) begin
                heading_r <= $signed({2'b00, side_r});
              end else if (new_dx == -STICK_FULL && new_dy == 16'sd0) begin
                heading_r <= -$signed({2'b00, side_r});
              end else if (new_dx == -STICK_FULL && new_dy == -STICK_FULL) begin
                heading_r <= -$signed({2'b00, diag_r}); mode_r <= MODE_BACK;
              end else if (new_dx == STICK_FULL && new_dy == -STICK_FULL) begin
                heading_r <= $signed({2'b00, diag_r}); mode_r <= MODE_BACK;
              end
            end
          end
          ACT_BUTTON: begin
            if (in_item.control_number == BTN_INC && in_item.control_value == 16'sd1) begin
              pwm_r <= (pwm_sum <= {1'b0, ceiling_r}) ? pwm_sum[11:0] : ceiling_r;
            end else if (in_item.control_number == BTN_DEC &&
                         in_item.control_value == 16'sd1) begin
              pwm_r <= (pwm_r >= {4'd0, step_r}) ? pwm_r - {4'd0, step_r} : 12'd0;
            end else if (in_item.control_number == BTN_CLEAR) begin
              mode_r <= MODE_STOP; pwm_r <= '0; heading_r <= '0;
            end
          end
          ACT_FACE: begin
            heading_r <= fd[16] ? -ft : ft;
            pwm_r     <= face_pwm_r;
            mode_r    <= (fm > deadband_r) ? MODE_FWD : MODE_STOP;
          end
          ACT_NONE: begin
            mode_r <= MODE_STOP; pwm_r <= '0; heading_r <= '0;
          end
          default: ;
        endcase
      end
      if (state_r == S_END) begin
        pwm_r <= root_r;
        if (folded > lim_s) heading_r <= lim_s;
        else if (folded < -lim_s) heading_r <= -lim_s;
        else begin
          heading_r <= folded;
          mode_r <= front ? MODE_FWD : MODE_BACK;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_mode_r <= mode_r;
      out_pwm_r  <= pwm_r;
      out_head_r <= heading_r;
    end
  end

  assign out_item.valid         = out_valid_r;
  assign out_item.motor_mode    = out_mode_r;
  assign out_item.pwm_level     = out_pwm_r;
  assign out_item.heading_delta = out_head_r;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_item.ready)
    else $error("ready high right after an accepted item");
  a_cordic_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COR) |-> (i_r < 5'(CordicSteps)))
    else $error("CORDIC step count out of range");
  a_mode_code: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> (mode_r != 2'd2))
    else $error("invalid motor mode at result");
  a_pending_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_item.ready) |=> out_valid_r)
    else $error("pending result dropped");
`endif

endmodule

// ===== dv/jmcm_command_checker.sv =====
// Watches the event and command channels, predicts each command and compares it.
module jmcm_command_checker
  import jmcm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  jmcm_in_if               ev_mon,
  jmcm_out_if              cmd_mon,
  input  logic             cfg_we,
  input  logic [CfgAw-1:0] cfg_addr,
  input  logic [CfgW-1:0]  cfg_wdata,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic [1:0]         mode;
    logic [11:0]        pwm;
    logic signed [15:0] heading;
  } motion_cmd_t;

  localparam longint AtanTab [18] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29
  };

  motion_cmd_t expected_cmds[$];

  logic [11:0] full_scale, ceiling, face_level;
  logic [7:0]  step;
  logic [14:0] head_lim;
  logic [13:0] diag_head, side_head;
  logic [15:0] deadband;

  logic signed [15:0] stick_x, stick_y, dpad_x, dpad_y, heading_q;
  logic [1:0]         mode_q;
  logic [11:0]        pwm_q;

  function automatic logic signed [15:0] neg_clip(input logic signed [15:0] v);
    return (v == -16'sd32768) ? 16'sd32767 : -v;
  endfunction

  function automatic int mag_clip(input logic signed [15:0] v);
    return (v < 0) ? int'(neg_clip(v)) : int'(v);
  endfunction

  // atan(ax/ay) in hundredths of a degree via vectoring rotations
  function automatic int stick_angle(input int ax, input int ay);
    longint p, q, z, dp, dq;
    if (ax == 0) return 0;
    if (ay == 0) return 9000;
    if (ax == ay) return 4500;
    p = longint'(ay) * 16384;
    q = longint'(ax) * 16384;
    z = 0;
    for (int i = 0; i < 18; i++) begin
      dp = q >>> i;
      dq = p >>> i;
      if (q >= 0) begin
        p += dp; q -= dq; z += AtanTab[i];
      end else begin
        p -= dp; q += dq; z -= AtanTab[i];
      end
    end
    if (z < 0) z = 0;
    if (z > 90 * 65536) z = 90 * 65536;
    return int'((z * 100) >>> 16);
  endfunction

  function automatic int stick_level(input int ax, input int ay, input int fs);
    longint unsigned prod, r, c;
    if (ax > 0 && ay > 0) begin
      prod = longint'(ax) * longint'(ay) * longint'(fs) * longint'(fs);
      r = 0;
      for (int b = 11; b >= 0; b--) begin
        c = (r | (64'd1 << b)) * 32767;
        if (c * c <= prod) r = r | (64'd1 << b);
      end
      return int'(r);
    end
    if (ax > 0) return int'((longint'(ax) * fs) / 32767);
    if (ay > 0) return int'((longint'(ay) * fs) / 32767);
    return 0;
  endfunction

  task automatic clear_command();
    mode_q = MODE_STOP;
    pwm_q = '0;
    heading_q = '0;
  endtask

  task automatic stick_move();
    int ax, ay, h, folded, lim;
    bit front;
    if (stick_x == 0 && stick_y == 0) begin
      clear_command();
      return;
    end
    ax = mag_clip(stick_x);
    ay = mag_clip(stick_y);
    h = stick_angle(ax, ay);
    front = (stick_y >= 0);
    if (front) folded = (stick_x < 0) ? -h : h;
    else folded = (stick_x < 0) ? h : -h;
    lim = int'(head_lim);
    pwm_q = 12'(stick_level(ax, ay, int'(full_scale)));
    if (folded > lim) heading_q = 16'(lim);
    else if (folded < -lim) heading_q = 16'(-lim);
    else begin
      heading_q = 16'(folded);
      mode_q = front ? MODE_FWD : MODE_BACK;
    end
  endtask

  task automatic dpad_move();
    int dg, sd, x, y;
    dg = int'(diag_head);
    sd = int'(side_head);
    x = int'(dpad_x);
    y = int'(dpad_y);
    if (x == 0 && y == 0) heading_q = '0;
    else if (x == 0 && y == 32767) begin
      heading_q = '0; mode_q = MODE_FWD;
    end else if (x == 0 && y == -32767) begin
      heading_q = '0; mode_q = MODE_BACK;
    end else if (x == 32767 && y == 32767) begin
      heading_q = 16'(dg); mode_q = MODE_FWD;
    end else if (x == -32767 && y == 32767) begin
      heading_q = 16'(-dg); mode_q = MODE_FWD;
    end else if (x == 32767 && y == 0) heading_q = 16'(sd);
    else if (x == -32767 && y == 0) heading_q = 16'(-sd);
    else if (x == -32767 && y == -32767) begin
      heading_q = 16'(-dg); mode_q = MODE_BACK;
    end else if (x == 32767 && y == -32767) begin
      heading_q = 16'(dg); mode_q = MODE_BACK;
    end
  endtask

  task automatic predict_command(input logic [2:0] act, input logic [7:0] num,
                                 input logic signed [15:0] val, input logic [15:0] fx);
    int d, m, t;
    motion_cmd_t c;
    case (act)
      ACT_AXIS: begin
        if (num == AXIS_STICK_X) begin
          stick_x = val; stick_move();
        end else if (num == AXIS_STICK_Y) begin
          stick_y = neg_clip(val); stick_move();
        end else if (num == AXIS_DPAD_X) begin
          dpad_x = val; dpad_move();
        end else if (num == AXIS_DPAD_Y) begin
          dpad_y = neg_clip(val); dpad_move();
        end
      end
      ACT_BUTTON: begin
        if (num == BTN_INC && val == 1) begin
          if (int'(pwm_q) + int'(step) <= int'(ceiling)) pwm_q = 12'(int'(pwm_q) + int'(step));
          else pwm_q = ceiling;
        end else if (num == BTN_DEC && val == 1) begin
          if (int'(pwm_q) >= int'(step)) pwm_q = 12'(int'(pwm_q) - int'(step));
          else pwm_q = '0;
        end else if (num == BTN_CLEAR) clear_command();
      end
      ACT_FACE: begin
        d = int'(fx) - 32768;
        m = (d < 0) ? -d : d;
        t = (m * 9000) / 65536;
        heading_q = 16'((d < 0) ? -t : t);
        pwm_q = face_level;
        mode_q = (m > int'(deadband)) ? MODE_FWD : MODE_STOP;
      end
      ACT_NONE: clear_command();
      default: ;
    endcase
    c.mode = mode_q;
    c.pwm = pwm_q;
    c.heading = heading_q;
    expected_cmds.push_back(c);
  endtask

  always @(posedge clk) begin
    motion_cmd_t e;
    if (!rst_n) begin
      full_scale = 12'd2499; ceiling = 12'd2449; step = 8'd10; head_lim = 15'd6000;
      diag_head = 14'd1000; side_head = 14'd4500; deadband = 16'd6554; face_level = 12'd10;
      stick_x = '0; stick_y = '0; dpad_x = '0; dpad_y = '0;
      clear_command();
      expected_cmds.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_FULL_SCALE: full_scale = cfg_wdata[11:0];
          REG_CEILING:    ceiling = cfg_wdata[11:0];
          REG_STEP:       step = cfg_wdata[7:0];
          REG_HEAD_LIM:   head_lim = cfg_wdata[14:0];
          REG_DIAG:       diag_head = cfg_wdata[13:0];
          REG_SIDE:       side_head = cfg_wdata[13:0];
          REG_DEADBAND:   deadband = cfg_wdata;
          REG_FACE_PWM:   face_level = cfg_wdata[11:0];
          default: ;
        endcase
      end
      // compare before pushing: a result never belongs to an item taken at the same edge
      if (cmd_mon.valid && cmd_mon.ready) begin
        if (expected_cmds.size() == 0) begin
          $error("command item with none expected");
          fail_count++;
        end else begin
          e = expected_cmds.pop_front();
          if (cmd_mon.motor_mode !== e.mode) begin
            $error("motor_mode expected %0d actual %0d", e.mode, cmd_mon.motor_mode);
            fail_count++;
          end
          if (cmd_mon.pwm_level !== e.pwm) begin
            $error("pwm_level expected %0d actual %0d", e.pwm, cmd_mon.pwm_level);
            fail_count++;
          end
          if (cmd_mon.heading_delta !== e.heading) begin
            $error("heading_delta expected %0d actual %0d", e.heading, cmd_mon.heading_delta);
            fail_count++;
          end
        end
      end
      if (ev_mon.valid && ev_mon.ready)
        predict_command(ev_mon.action, ev_mon.control_number, ev_mon.control_value,
                        ev_mon.face_x);
    end
    pending = expected_cmds.size();
  end

endmodule

// ===== dv/joystick_motion_command_mapper_core_tb.sv =====
// Stimulus, configuration phases and verdict for the motion command mapper.
module joystick_motion_command_mapper_core_tb;
  import jmcm_pkg::*;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CfgAw-1:0] cfg_addr;
  logic [CfgW-1:0]  cfg_wdata;
  int               fail_count, pending;
  int               quiet_cycles;
  bit               sender_idles, receiver_stalls, hold_req;
  int               hold_cnt;
  int               idle_pct;

  jmcm_in_if  ev_ch ();
  jmcm_out_if cmd_ch ();

  joystick_motion_command_mapper_core uut (
    .clk(clk), .rst_n(rst_n), .in_item(ev_ch.sink), .out_item(cmd_ch.source),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  jmcm_command_checker chk (
    .clk(clk), .rst_n(rst_n), .ev_mon(ev_ch), .cmd_mon(cmd_ch),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req && hold_cnt == 0) hold_cnt <= 400;
    else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
    if (hold_cnt > 1 || (hold_req && hold_cnt == 0)) cmd_ch.ready <= 1'b0;
    else cmd_ch.ready <= receiver_stalls ? ($urandom_range(0, 99) >= idle_pct) : 1'b1;
  end

  always @(posedge clk) begin
    if ((ev_ch.valid && ev_ch.ready) || (cmd_ch.valid && cmd_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == 5000) begin
      $display("joystick_motion_command_mapper_core test failed");
      $finish;
    end
  end

  task automatic send_event(input logic [2:0] act, input logic [7:0] num,
                            input logic signed [15:0] val, input logic [15:0] fx);
    if (sender_idles) begin
      while ($urandom_range(0, 99) < idle_pct) begin
        ev_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    ev_ch.valid <= 1'b1;
    ev_ch.action <= act;
    ev_ch.control_number <= num;
    ev_ch.control_value <= val;
    ev_ch.face_x <= fx;
    do @(posedge clk); while (!ev_ch.ready);
  endtask

  function automatic logic signed [15:0] stick_value();
    case ($urandom_range(0, 5))
      0: return -16'sd32768;
      1: return -16'sd32767;
      2: return 16'sd0;
      3: return 16'sd32767;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] dpad_value();
    case ($urandom_range(0, 7))
      0, 1: return -16'sd32767;
      2, 3: return 16'sd0;
      4, 5: return 16'sd32767;
      6: return -16'sd32768;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random_event();
    int r;
    logic [7:0] num;
    logic signed [15:0] val;
    r = $urandom_range(0, 99);
    if (r < 35)
      send_event(ACT_AXIS, $urandom_range(0, 1) ? AXIS_STICK_X : AXIS_STICK_Y, stick_value(),
                 16'($urandom));
    else if (r < 55)
      send_event(ACT_AXIS, $urandom_range(0, 1) ? AXIS_DPAD_X : AXIS_DPAD_Y, dpad_value(),
                 16'($urandom));
    else if (r < 75) begin
      case ($urandom_range(0, 4))
        0, 1: num = BTN_INC;
        2: num = BTN_DEC;
        3: num = BTN_CLEAR;
        default: num = 8'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0: val = 16'($urandom);
        1: val = 16'sd0;
        default: val = 16'sd1;
      endcase
      send_event(ACT_BUTTON, num, val, 16'($urandom));
    end else if (r < 85)
      send_event(ACT_FACE, 8'($urandom), 16'($urandom), 16'($urandom));
    else if (r < 90)
      send_event(ACT_BODY, 8'($urandom), 16'($urandom), 16'($urandom));
    else if (r < 95)
      send_event(ACT_NONE, 8'($urandom), 16'($urandom), 16'($urandom));
    else if (r < 98)
      send_event(ACT_AXIS, 8'($urandom), 16'($urandom), 16'($urandom));
    else
      send_event(3'($urandom_range(5, 7)), 8'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic write_reg(input logic [CfgAw-1:0] a, input int v);
    cfg_we <= 1'b1;
    cfg_addr <= a;
    cfg_wdata <= 16'(v);
    @(posedge clk);
  endtask

  // drain, let a stick item finish, then load a register set
  task automatic load_setting(input int sel);
    ev_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    case (sel)
      0: begin
        write_reg(REG_FULL_SCALE, 2499); write_reg(REG_CEILING, 2449);
        write_reg(REG_STEP, 10);         write_reg(REG_HEAD_LIM, 6000);
        write_reg(REG_DIAG, 1000);       write_reg(REG_SIDE, 4500);
        write_reg(REG_DEADBAND, 6554);   write_reg(REG_FACE_PWM, 10);
      end
      1: begin
        write_reg(REG_FULL_SCALE, 4095); write_reg(REG_CEILING, 4095);
        write_reg(REG_STEP, 255);        write_reg(REG_HEAD_LIM, 18000);
        write_reg(REG_DIAG, 9000);       write_reg(REG_SIDE, 9000);
        write_reg(REG_DEADBAND, 32768);  write_reg(REG_FACE_PWM, 4095);
      end
      2: begin
        write_reg(REG_FULL_SCALE, 0); write_reg(REG_CEILING, 0);
        write_reg(REG_STEP, 0);       write_reg(REG_HEAD_LIM, 0);
        write_reg(REG_DIAG, 0);       write_reg(REG_SIDE, 0);
        write_reg(REG_DEADBAND, 0);   write_reg(REG_FACE_PWM, 0);
      end
      default: begin
        write_reg(REG_FULL_SCALE, $urandom_range(0, 4095));
        write_reg(REG_CEILING, $urandom_range(0, 4095));
        write_reg(REG_STEP, $urandom_range(0, 255));
        write_reg(REG_HEAD_LIM, $urandom_range(0, 18000));
        write_reg(REG_DIAG, $urandom_range(0, 9000));
        write_reg(REG_SIDE, $urandom_range(0, 9000));
        write_reg(REG_DEADBAND, $urandom_range(0, 32768));
        write_reg(REG_FACE_PWM, $urandom_range(0, 4095));
      end
    endcase
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_addr <= '0;
    cfg_wdata <= '0;
    ev_ch.valid <= 1'b0;
    ev_ch.action <= ACT_BODY;
    ev_ch.control_number <= '0;
    ev_ch.control_value <= '0;
    ev_ch.face_x <= '0;
    sender_idles = 0;
    receiver_stalls = 0;
    idle_pct = 76;
    hold_req = 0;
    hold_cnt = 0;
    quiet_cycles = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: stick extremes and special magnitudes
    send_event(ACT_AXIS, AXIS_STICK_X, -16'sd32768, 16'd0);
    send_event(ACT_AXIS, AXIS_STICK_Y, -16'sd32768, 16'd0);
    send_event(ACT_AXIS, AXIS_STICK_Y, 16'sd32767, 16'd0);
    send_event(ACT_AXIS, AXIS_STICK_X, 16'sd0, 16'd0);
    send_event(ACT_AXIS, AXIS_STICK_Y, 16'sd0, 16'd0);
    send_event(ACT_AXIS, AXIS_STICK_X, 16'sd1000, 16'd0);
    send_event(ACT_AXIS, AXIS_STICK_Y, 16'sd1000, 16'd0);
    send_event(ACT_AXIS, 8'd0, 16'sd5000, 16'd0);
    send_event(ACT_AXIS, 8'd255, 16'sd5000, 16'd0);
    // d-pad table corners, then buttons and the other actions
    send_event(ACT_AXIS, AXIS_DPAD_X, 16'sd32767, 16'd0);
    send_event(ACT_AXIS, AXIS_DPAD_Y, -16'sd32767, 16'd0);
    send_event(ACT_AXIS, AXIS_DPAD_Y, -16'sd32768, 16'd0);
    send_event(ACT_AXIS, AXIS_DPAD_X, -16'sd32767, 16'd0);
    send_event(ACT_AXIS, AXIS_DPAD_X, 16'sd123, 16'd0);
    send_event(ACT_BUTTON, BTN_INC, 16'sd1, 16'd0);
    send_event(ACT_BUTTON, BTN_INC, 16'sd2, 16'd0);
    send_event(ACT_BUTTON, BTN_DEC, 16'sd1, 16'd0);
    send_event(ACT_BUTTON, BTN_CLEAR, 16'sd0, 16'd0);
    send_event(ACT_BUTTON, 8'd200, 16'sd1, 16'd0);
    send_event(ACT_FACE, 8'd0, 16'sd0, 16'd0);
    send_event(ACT_FACE, 8'd0, 16'sd0, 16'hFFFF);
    send_event(ACT_FACE, 8'd0, 16'sd0, 16'h8000);
    send_event(ACT_BODY, 8'd0, 16'sd0, 16'd0);
    send_event(ACT_NONE, 8'd0, 16'sd0, 16'd0);
    send_event(3'd7, 8'd2, 16'sd100, 16'd0);

    for (int ph = 0; ph < 8; ph++) begin
      load_setting(ph % 4);
      sender_idles = (ph % 4 == 1) || (ph % 4 == 3);
      receiver_stalls = (ph % 4 >= 2);
      idle_pct = (ph % 4 == 3) ? 22 : 76;
      for (int k = 0; k < 50; k++) begin
        if (ph == 0 && k == 5) hold_req = 1;
        if (ph == 0 && k == 10) hold_req = 0;
        send_random_event();
      end
    end
    ev_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) $display("joystick_motion_command_mapper_core test passed");
    else $display("joystick_motion_command_mapper_core test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/jmcm_pkg.sv
rtl/jmcm_if.sv
rtl/joystick_motion_command_mapper_core.sv
dv/jmcm_command_checker.sv
dv/joystick_motion_command_mapper_core_tb.sv
